// ===== rtl/klis_pkg.sv =====
// ----------------------------------------------------------------------------
// klis_pkg: shared definitions for the k-mer location index search block
// Field widths, opcodes, the signed pointer type used by the search loop and
// the flag bundle that the probe unit returns to the sequencer.
// ----------------------------------------------------------------------------
package klis_pkg;

   // Default sizing of the index.
   localparam int KMER_LEN_DEF  = 8;
   localparam int LOC_DEPTH_DEF = 65536;

   // Field widths.
   localparam int OP_W   = 3;
   localparam int IDX_W  = 17;
   localparam int WORD_W = 32;
   localparam int OFF_W  = 17;
   localparam int CNT_W  = 17;

   // Search pointers reach one below zero and one past the largest offset.
   localparam int PTR_W = IDX_W + 2;

   // Stream widths; the data payloads are padded to whole bytes.
   localparam int REQ_TDATA_W = 88;
   localparam int REQ_TUSER_W = OP_W;
   localparam int RSP_TDATA_W = 72;
   localparam int RSP_TUSER_W = 1;

   // Opcodes.
   localparam logic [OP_W-1:0] OP_WR_OFF = 3'd0;
   localparam logic [OP_W-1:0] OP_WR_LOC = 3'd1;
   localparam logic [OP_W-1:0] OP_RANGE  = 3'd2;
   localparam logic [OP_W-1:0] OP_NEAR   = 3'd3;
   localparam logic [OP_W-1:0] OP_EXACT  = 3'd4;
   localparam logic [OP_W-1:0] OP_RD_LOC = 3'd5;

   typedef logic signed [PTR_W-1:0] ptr_type;
   typedef logic [WORD_W-1:0]       word_type;

   // Status from the probe unit back to the sequencer.
   typedef struct packed {
      logic open;       // lo is below hi: the loop keeps probing
      logic in_bucket;  // the next midpoint lies inside the bucket
      logic hit;        // the probed word satisfies the query
      logic below;      // the probed word is below the target
   } probe_flags_type;

endpackage

// ===== rtl/klis_store.sv =====
// ----------------------------------------------------------------------------
// klis_store: offset table and location store
// Two simple dual-port memories, each with one write port and one read port
// whose data is registered. Contents are undefined until written.
// ----------------------------------------------------------------------------
module klis_store import klis_pkg::*; #(
   parameter int OFF_DEPTH = (1 << (2 * KMER_LEN_DEF)) + 1,
   parameter int LOC_DEPTH = LOC_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         off_we,
   input  logic [$clog2(OFF_DEPTH)-1:0] off_waddr,
   input  logic [OFF_W-1:0]             off_wdata,
   input  logic [$clog2(OFF_DEPTH)-1:0] off_raddr,
   output logic [OFF_W-1:0]             off_rdata,
   input  logic                         loc_we,
   input  logic [$clog2(LOC_DEPTH)-1:0] loc_waddr,
   input  word_type                     loc_wdata,
   input  logic [$clog2(LOC_DEPTH)-1:0] loc_raddr,
   output word_type                     loc_rdata
);

   logic [OFF_W-1:0] off_mem [OFF_DEPTH];
   word_type         loc_mem [LOC_DEPTH];
   logic [OFF_W-1:0] off_rdata_ff;
   word_type         loc_rdata_ff;

   // Offset table: one entry per bucket plus the end entry.
   always_ff @(posedge clock) begin
      if (off_we) begin
         off_mem[off_waddr] <= off_wdata;
      end
      off_rdata_ff <= off_mem[off_raddr];
   end

   // Location store, sorted within each bucket.
   always_ff @(posedge clock) begin
      if (loc_we) begin
         loc_mem[loc_waddr] <= loc_wdata;
      end
      loc_rdata_ff <= loc_mem[loc_raddr];
   end

   assign off_rdata = off_rdata_ff;
   assign loc_rdata = loc_rdata_ff;

endmodule

// ===== rtl/klis_probe.sv =====
// ----------------------------------------------------------------------------
// klis_probe: shared arithmetic and compare unit of the search
// Forms the next midpoint from the current bounds, the saturated tolerance
// window, and the match and direction tests on the word just read.
// ----------------------------------------------------------------------------
module klis_probe import klis_pkg::*; (
   input  ptr_type         lo,
   input  ptr_type         hi,
   input  ptr_type         bucket_start,
   input  ptr_type         bucket_end,
   input  logic            near,
   input  word_type        target,
   input  word_type        tolerance,
   input  word_type        win_lo,
   input  word_type        win_hi,
   input  word_type        rd_word,
   output ptr_type         mid,
   output word_type        win_lo_calc,
   output word_type        win_hi_calc,
   output probe_flags_type flags
);

   ptr_type           span;
   logic [WORD_W:0]   diff;
   logic [WORD_W:0]   sum;

   // Midpoint of the live range; it collapses to lo once the range is empty.
   always_comb begin
      span = hi - lo;
      if (hi >= lo) begin
         mid = lo + (span >>> 1);
      end else begin
         mid = lo;
      end
   end

   // Tolerance window, saturating at both ends of the word range.
   always_comb begin
      diff        = {1'b0, target} - {1'b0, tolerance};
      sum         = {1'b0, target} + {1'b0, tolerance};
      win_lo_calc = diff[WORD_W] ? '0 : diff[WORD_W-1:0];
      win_hi_calc = sum[WORD_W] ? '1 : sum[WORD_W-1:0];
   end

   // Loop control and match tests.
   always_comb begin
      flags.open      = lo < hi;
      flags.in_bucket = (mid >= bucket_start) && (mid < bucket_end);
      flags.below     = rd_word < target;
      if (near) begin
         flags.hit = (rd_word >= win_lo) && (rd_word <= win_hi);
      end else begin
         flags.hit = rd_word == target;
      end
   end

endmodule

// ===== rtl/kmer_location_index_search.sv =====
// ----------------------------------------------------------------------------
// kmer_location_index_search: bucketed location index with binary search
// Loads an offset table and a sorted location store, then answers bucket
// range, near search, exact find and location read queries.
// ----------------------------------------------------------------------------
// One request is handled at a time and each gives exactly one response. A
// write or an invalid opcode goes straight to the hand-over state. A
// location read passes through the read state first, unless the index lies
// past the store. A bucket range query fetches the start and end offsets,
// then forms the bounds; a bucket number past the table skips the fetch. A
// near search or exact find on an empty, inverted or missing bucket follows
// the same path. Otherwise the binary search loop follows, each probe being
// a registered location read at the midpoint, then the compare and bound
// update; when the loop ends without a hit the last midpoint is probed once
// more, unless it lies outside the bucket. The request side is ready again
// as soon as the response is loaded into the output register, even while
// that response still waits. Both tables hold garbage after reset and must
// be written before they are read; there is no clearing pass.
// ----------------------------------------------------------------------------
module kmer_location_index_search import klis_pkg::*; #(
   parameter int KMER_LEN  = KMER_LEN_DEF,
   parameter int LOC_DEPTH = LOC_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // index[16:0], value[48:17], tolerance[80:49], zero padding above
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // opcode[2:0]
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // position[16:0], count[33:17], location_word[65:34], zero padding above
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // found[0]
   output logic [RSP_TUSER_W-1:0] rsp_tuser
);

   localparam int NBUCKETS  = 1 << (2 * KMER_LEN);
   localparam int OFF_DEPTH = NBUCKETS + 1;
   localparam int OFF_AW    = $clog2(OFF_DEPTH);
   localparam int LOC_AW    = $clog2(LOC_DEPTH);

   localparam logic [31:0] BucketLimit = 32'(NBUCKETS);
   localparam logic [31:0] OffLimit    = 32'(OFF_DEPTH);
   localparam logic [31:0] LocLimit    = 32'(LOC_DEPTH);

   // Sequencer states.
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_OFF0   = 4'd1;
   localparam logic [3:0] S_OFF1   = 4'd2;
   localparam logic [3:0] S_BOUNDS = 4'd3;
   localparam logic [3:0] S_MID    = 4'd4;
   localparam logic [3:0] S_PROBE  = 4'd5;
   localparam logic [3:0] S_FINAL  = 4'd6;
   localparam logic [3:0] S_RDLOC  = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   logic [3:0]       state_ff, state_in;
   logic [OP_W-1:0]  op_ff, op_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   word_type         val_ff, val_in;
   word_type         tol_ff, tol_in;
   ptr_type          s_ff, s_in;
   ptr_type          e_ff, e_in;
   ptr_type          lo_ff, lo_in;
   ptr_type          hi_ff, hi_in;
   ptr_type          mid_ff, mid_in;
   word_type         win_lo_ff, win_lo_in;
   word_type         win_hi_ff, win_hi_in;
   logic             res_found_ff, res_found_in;
   logic [IDX_W-1:0] res_pos_ff, res_pos_in;
   logic [CNT_W-1:0] res_cnt_ff, res_cnt_in;
   word_type         res_word_ff, res_word_in;
   logic             rsp_tvalid_ff, rsp_tvalid_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [IDX_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic [CNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   word_type         rsp_word_ff, rsp_word_in;

   logic             req_xfer;
   logic [OP_W-1:0]  req_op;
   logic [IDX_W-1:0] req_index;
   word_type         req_value;
   word_type         req_tol;
   logic [31:0]      req_index32;

   logic              off_we;
   logic [OFF_AW-1:0] off_raddr;
   logic [OFF_W-1:0]  off_rdata;
   logic              loc_we;
   logic [LOC_AW-1:0] loc_raddr;
   word_type          loc_rdata;

   ptr_type          mid_calc;
   word_type         win_lo_calc;
   word_type         win_hi_calc;
   probe_flags_type  flags;
   ptr_type          span;
   ptr_type          mid_next;

   // Request unpacking.
   assign req_op      = req_tuser[OP_W-1:0];
   assign req_index   = req_tdata[IDX_W-1:0];
   assign req_value   = req_tdata[IDX_W+WORD_W-1:IDX_W];
   assign req_tol     = req_tdata[IDX_W+2*WORD_W-1:IDX_W+WORD_W];
   assign req_index32 = 32'(req_index);
   assign req_tready  = state_ff == S_IDLE;
   assign req_xfer    = req_tvalid && req_tready;

   klis_store #(
      .OFF_DEPTH (OFF_DEPTH),
      .LOC_DEPTH (LOC_DEPTH)
   ) u_store (
      .clock     (clock),
      .off_we    (off_we),
      .off_waddr (OFF_AW'(req_index)),
      .off_wdata (req_value[OFF_W-1:0]),
      .off_raddr (off_raddr),
      .off_rdata (off_rdata),
      .loc_we    (loc_we),
      .loc_waddr (LOC_AW'(req_index)),
      .loc_wdata (req_value),
      .loc_raddr (loc_raddr),
      .loc_rdata (loc_rdata)
   );

   klis_probe u_probe (
      .lo           (lo_ff),
      .hi           (hi_ff),
      .bucket_start (s_ff),
      .bucket_end   (e_ff),
      .near         (op_ff == OP_NEAR),
      .target       (val_ff),
      .tolerance    (tol_ff),
      .win_lo       (win_lo_ff),
      .win_hi       (win_hi_ff),
      .rd_word      (loc_rdata),
      .mid          (mid_calc),
      .win_lo_calc  (win_lo_calc),
      .win_hi_calc  (win_hi_calc),
      .flags        (flags)
   );

   assign span     = e_ff - s_ff;
   assign mid_next = mid_ff + PTR_W'(1);

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      val_in        = val_ff;
      tol_in        = tol_ff;
      s_in          = s_ff;
      e_in          = e_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      win_lo_in     = win_lo_ff;
      win_hi_in     = win_hi_ff;
      res_found_in  = res_found_ff;
      res_pos_in    = res_pos_ff;
      res_cnt_in    = res_cnt_ff;
      res_word_in   = res_word_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      off_we        = 1'b0;
      loc_we        = 1'b0;
      off_raddr     = OFF_AW'(req_index);
      loc_raddr     = LOC_AW'(req_index);

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               op_in        = req_op;
               idx_in       = req_index;
               val_in       = req_value;
               tol_in       = req_tol;
               res_found_in = 1'b0;
               res_pos_in   = '0;
               res_cnt_in   = '0;
               res_word_in  = '0;
               state_in     = S_DONE;
               unique case (req_op) inside
                  OP_WR_OFF: begin
                     off_we = req_index32 < OffLimit;
                  end
                  OP_WR_LOC: begin
                     loc_we = req_index32 < LocLimit;
                  end
                  OP_RANGE, OP_NEAR, OP_EXACT: begin
                     // A bucket number past the table is an empty bucket at 0.
                     s_in = '0;
                     e_in = '0;
                     if (req_index32 < BucketLimit) begin
                        state_in = S_OFF0;
                     end else begin
                        state_in = S_BOUNDS;
                     end
                  end
                  OP_RD_LOC: begin
                     if (req_index32 < LocLimit) begin
                        state_in = S_RDLOC;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_OFF0: begin
            // Start offset arrives; fetch the next entry as the end.
            s_in      = ptr_type'({2'b00, off_rdata});
            off_raddr = OFF_AW'({1'b0, idx_ff} + 18'd1);
            state_in  = S_OFF1;
         end
         S_OFF1: begin
            // A bucket end past the store is clamped to the store depth.
            if (32'(off_rdata) > LocLimit) begin
               e_in = ptr_type'(LocLimit[PTR_W-1:0]);
            end else begin
               e_in = ptr_type'({2'b00, off_rdata});
            end
            state_in = S_BOUNDS;
         end
         S_BOUNDS: begin
            // An inverted bucket counts as empty.
            res_cnt_in = (e_ff > s_ff) ? span[CNT_W-1:0] : '0;
            state_in   = S_DONE;
            if (op_ff == OP_RANGE) begin
               res_found_in = e_ff > s_ff;
               res_pos_in   = s_ff[IDX_W-1:0];
            end else begin
               res_pos_in = (op_ff == OP_NEAR) ? s_ff[IDX_W-1:0] : '0;
               if (e_ff > s_ff) begin
                  lo_in     = s_ff;
                  hi_in     = e_ff - PTR_W'(1);
                  win_lo_in = win_lo_calc;
                  win_hi_in = win_hi_calc;
                  state_in  = S_MID;
               end
            end
         end
         S_MID: begin
            // Issue the read at the midpoint; the last probe stays in the bucket.
            mid_in    = mid_calc;
            loc_raddr = LOC_AW'($unsigned(mid_calc));
            if (flags.open) begin
               state_in = S_PROBE;
            end else if (flags.in_bucket) begin
               state_in = S_FINAL;
            end else begin
               state_in = S_DONE;
            end
         end
         S_PROBE: begin
            if (flags.hit) begin
               res_found_in = 1'b1;
               res_word_in  = loc_rdata;
               if (op_ff == OP_EXACT) begin
                  res_pos_in = mid_next[IDX_W-1:0];
               end
               state_in = S_DONE;
            end else begin
               if (flags.below) begin
                  lo_in = mid_next;
               end else begin
                  hi_in = mid_ff - PTR_W'(1);
               end
               state_in = S_MID;
            end
         end
         S_FINAL: begin
            if (flags.hit) begin
               res_found_in = 1'b1;
               res_word_in  = loc_rdata;
               if (op_ff == OP_EXACT) begin
                  res_pos_in = mid_next[IDX_W-1:0];
               end
            end
            state_in = S_DONE;
         end
         S_RDLOC: begin
            res_found_in = 1'b1;
            res_word_in  = loc_rdata;
            state_in     = S_DONE;
         end
         S_DONE: begin
            // Move the result into the output register once it is free.
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_found_in  = res_found_ff;
               rsp_pos_in    = res_pos_ff;
               rsp_cnt_in    = res_cnt_ff;
               rsp_word_in   = res_word_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Working and result registers.
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      idx_ff       <= idx_in;
      val_ff       <= val_in;
      tol_ff       <= tol_in;
      s_ff         <= s_in;
      e_ff         <= e_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      win_lo_ff    <= win_lo_in;
      win_hi_ff    <= win_hi_in;
      res_found_ff <= res_found_in;
      res_pos_ff   <= res_pos_in;
      res_cnt_ff   <= res_cnt_in;
      res_word_ff  <= res_word_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_word_ff  <= rsp_word_in;
   end

   // Response packing.
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - IDX_W - CNT_W - WORD_W){1'b0}},
                        rsp_word_ff, rsp_cnt_ff, rsp_pos_ff};
   assign rsp_tuser  = rsp_found_ff;

   // The live search range never leaves the bucket.
   a_loop_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MID && flags.open) |-> (lo_ff >= s_ff && hi_ff < e_ff))
      else $error("search range left the bucket");

   // Every location probe reads inside the bucket.
   a_probe_in_bucket: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE || state_ff == S_FINAL) |-> (mid_ff >= s_ff && mid_ff < e_ff))
      else $error("probe outside the bucket");

   // A successful exact find reports a nonzero position.
   a_exact_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && res_found_ff && op_ff == OP_EXACT) |-> (res_pos_ff != '0))
      else $error("exact find hit with zero position");

   // A response only appears when the sequencer hands one over.
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside the hand-over state");

   // Table writes answer with a cleared result.
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && (op_ff == OP_WR_OFF || op_ff == OP_WR_LOC))
      |-> (!res_found_ff && res_word_ff == '0 && res_cnt_ff == '0))
      else $error("write produced a nonzero result");

endmodule

// ===== test/tb_kmer_location_index_search.sv =====
// ----------------------------------------------------------------------------
// tb_kmer_location_index_search: self-checking bench for the location index
// Loads buckets of sorted locations through the request stream, then issues
// range, near, exact and read queries against them. A scoreboard keeps its
// own copy of both tables, predicts every response and compares it field by
// field. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_kmer_location_index_search;
   import klis_pkg::*;

   localparam int NUM_BUCKETS  = 1 << (2 * KMER_LEN_DEF);
   localparam int STORE_DEPTH  = LOC_DEPTH_DEF;
   localparam int ITEM_TARGET  = 1650;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 64;
   localparam int MAX_REPORTS  = 10;
   localparam int MAX_GAP      = 14;

   // Opcodes that the block treats as no operation.
   localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
   localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] position;
      logic [CNT_W-1:0] count;
      word_type         location_word;
   } index_answer_type;

   // Shadow of both tables plus the queue of answers still owed by the block.
   class loc_index_scoreboard;
      bit [OFF_W-1:0]   offset_table [0:NUM_BUCKETS];
      bit               offset_written [0:NUM_BUCKETS];
      word_type         location_store [0:STORE_DEPTH-1];
      bit               location_written [0:STORE_DEPTH-1];
      index_answer_type pending_answers [$];
      int               mismatches;
      int               checked;
      int               hits;

      // Start, clamped end and length of one bucket.
      function void bucket_span(input longint bucket, output longint span_lo,
                                output longint span_hi, output longint span_len);
         span_lo = 0;
         span_hi = 0;
         if (bucket < NUM_BUCKETS) begin
            span_lo = offset_table[bucket];
            span_hi = offset_table[bucket + 1];
            if (span_hi > STORE_DEPTH) span_hi = STORE_DEPTH;
         end
         span_len = (span_hi > span_lo) ? span_hi - span_lo : 0;
      endfunction

      function word_type stored_word(input longint p);
         if (p < 0 || p >= STORE_DEPTH) return '0;
         return location_store[p];
      endfunction

      function bit word_matches(input bit is_near, input word_type w, input word_type target,
                                input word_type low_bound, input word_type high_bound);
         return is_near ? (w >= low_bound && w <= high_bound) : (w == target);
      endfunction

      // True when the query touches only table entries that hold written data.
      function bit query_is_defined(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx);
         longint span_lo, span_hi, span_len;
         if (op == OP_RD_LOC) return idx >= STORE_DEPTH || location_written[idx];
         if (op != OP_RANGE && op != OP_NEAR && op != OP_EXACT) return 1'b1;
         if (idx >= NUM_BUCKETS) return 1'b1;
         if (!offset_written[idx] || !offset_written[idx + 1]) return 1'b0;
         if (op == OP_RANGE) return 1'b1;
         bucket_span(idx, span_lo, span_hi, span_len);
         for (longint p = span_lo; p < span_hi; p++)
            if (!location_written[p]) return 1'b0;
         return 1'b1;
      endfunction

      // Applies one request to the shadow tables and returns its answer.
      function index_answer_type answer_for(input logic [OP_W-1:0] op,
                                            input logic [IDX_W-1:0] idx,
                                            input word_type target, input word_type tol);
         index_answer_type r;
         longint span_lo, span_hi, span_len, lo, hi, mid;
         word_type low_bound, high_bound, w;
         bit hit, is_near;
         r = '0;
         is_near = (op == OP_NEAR);
         case (op)
            OP_WR_OFF: begin
               if (idx <= NUM_BUCKETS) begin
                  offset_table[idx]   = target[OFF_W-1:0];
                  offset_written[idx] = 1'b1;
               end
            end
            OP_WR_LOC: begin
               if (idx < STORE_DEPTH) begin
                  location_store[idx]   = target;
                  location_written[idx] = 1'b1;
               end
            end
            OP_RANGE: begin
               bucket_span(idx, span_lo, span_hi, span_len);
               r.position = IDX_W'(span_lo);
               r.count    = CNT_W'(span_len);
               r.found    = (span_len != 0);
            end
            OP_NEAR, OP_EXACT: begin
               bucket_span(idx, span_lo, span_hi, span_len);
               r.count = CNT_W'(span_len);
               if (is_near) r.position = IDX_W'(span_lo);
               if (span_len != 0) begin
                  // Window around the target, saturating at both ends.
                  low_bound  = (target >= tol) ? target - tol : '0;
                  high_bound = (target <= ~tol) ? target + tol : '1;
                  lo  = span_lo;
                  hi  = span_hi - 1;
                  mid = lo + (hi - lo) / 2;
                  hit = 1'b0;
                  while (lo < hi && !hit) begin
                     w = stored_word(mid);
                     if (word_matches(is_near, w, target, low_bound, high_bound)) begin
                        hit = 1'b1;
                     end else begin
                        if (w < target) lo = mid + 1;
                        else hi = mid - 1;
                        mid = (hi >= lo) ? lo + (hi - lo) / 2 : lo;
                     end
                  end
                  // The last probe counts only when it still lies in the bucket.
                  if (!hit && mid >= span_lo && mid < span_hi)
                     hit = word_matches(is_near, stored_word(mid), target, low_bound,
                                        high_bound);
                  if (hit) begin
                     r.found         = 1'b1;
                     r.location_word = stored_word(mid);
                     if (op == OP_EXACT) r.position = IDX_W'(mid + 1);
                  end
               end
            end
            OP_RD_LOC: begin
               if (idx < STORE_DEPTH) begin
                  r.found         = 1'b1;
                  r.location_word = location_store[idx];
               end
            end
            default: ;
         endcase
         return r;
      endfunction

      function void note_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                 input word_type target, input word_type tol);
         index_answer_type answer;
         answer = answer_for(op, idx, target, tol);
         pending_answers = {pending_answers, answer};
      endfunction

      function void check_response(input index_answer_type got);
         index_answer_type want;
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("response with nothing outstanding: %s%0d %s%0d %s%0d %s%h",
                        "found=", got.found, "position=", got.position,
                        "count=", got.count, "word=", got.location_word);
            return;
         end
         want = pending_answers.pop_front();
         checked++;
         if (want.found) hits++;
         if (got.found !== want.found || got.position !== want.position ||
             got.count !== want.count || got.location_word !== want.location_word) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("response %0d mismatch:", checked);
               $display("   expected found=%0d position=%0d count=%0d word=%h",
                        want.found, want.position, want.count, want.location_word);
               $display("   actual   found=%0d position=%0d count=%0d word=%h",
                        got.found, got.position, got.count, got.location_word);
            end
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   loc_index_scoreboard board = new();
   bit                  req_idle_on = 1'b1;
   bit                  rsp_idle_on = 1'b1;
   int                  items_sent;
   int                  buckets_loaded;
   int                  alloc_ptr;
   int                  cycle_count;
   int                  built_buckets [$];

   kmer_location_index_search #(
      .KMER_LEN  (KMER_LEN_DEF),
      .LOC_DEPTH (LOC_DEPTH_DEF)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Clock with a period of two time units.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Hard stop in case the block hangs.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_kmer_location_index_search: errors");
      $finish;
   end

   // Drives one request and returns at the edge where its transfer happens.
   task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                               input word_type val, input word_type tol);
      int gap;
      gap = req_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_TDATA_W'({tol, val, idx});
      do @(posedge clock); while (req_tready !== 1'b1);
      board.note_request(op, idx, val, tol);
      items_sent++;
   endtask

   // One query on a bucket, aimed mostly at locations it really holds.
   task automatic query_bucket(input int bucket);
      longint           span_lo, span_hi, span_len;
      logic [OP_W-1:0]  op;
      logic [IDX_W-1:0] idx;
      word_type         target, tol;
      int               pick;
      board.bucket_span(bucket, span_lo, span_hi, span_len);
      pick = $urandom_range(0, 99);
      if (pick < 15) op = OP_RANGE;
      else if (pick < 55) op = OP_NEAR;
      else if (pick < 90) op = OP_EXACT;
      else op = OP_RD_LOC;
      idx = IDX_W'(bucket);
      target = $urandom;
      if (span_len > 0 && $urandom_range(0, 9) < 7) begin
         target = board.stored_word(span_lo + $urandom_range(0, int'(span_len) - 1));
         case ($urandom_range(0, 3))
            0: target = target + $urandom_range(1, 20);
            1: target = target - $urandom_range(1, 20);
            default: ;
         endcase
      end else if ($urandom_range(0, 4) == 0) begin
         target = $urandom_range(0, 1) ? '0 : '1;
      end
      case ($urandom_range(0, 3))
         0: tol = '0;
         1: tol = $urandom_range(0, 16);
         2: tol = $urandom;
         default: tol = word_type'('1) - $urandom_range(0, 16);
      endcase
      if (op == OP_RD_LOC)
         idx = (span_len > 0) ? IDX_W'(span_lo + $urandom_range(0, int'(span_len) - 1))
                              : IDX_W'($urandom);
      // Steer away from entries that were never written.
      if (!board.query_is_defined(op, idx)) idx[IDX_W-1] = 1'b1;
      send_request(op, idx, target, tol);
   endtask

   // Loads one bucket as a proper sorted run, then queries it a few times.
   task automatic build_bucket();
      int       bucket, len, start, mode, pick;
      word_type base, val;
      word_type locs [$];
      pick = $urandom_range(0, 99);
      if (pick < 8) len = 0;
      else if (pick < 96) len = $urandom_range(1, 12);
      else len = $urandom_range(30, 120);
      if (built_buckets.size() > 0 && built_buckets[$] < NUM_BUCKETS - 1 &&
          $urandom_range(0, 3) == 0)
         bucket = built_buckets[$] + 1;
      else
         bucket = $urandom_range(0, NUM_BUCKETS - 1);
      if (alloc_ptr + len > STORE_DEPTH) alloc_ptr = 0;
      start = alloc_ptr;
      alloc_ptr += len;
      mode = $urandom_range(0, 3);
      base = $urandom;
      for (int i = 0; i < len; i++) begin
         case (mode)
            0: val = $urandom;
            1: val = $urandom_range(0, 300);
            2: val = word_type'('1) - $urandom_range(0, 300);
            default: val = base + $urandom_range(0, 6);
         endcase
         locs = {locs, val};
      end
      locs.sort();
      // Offsets carry random junk above the 17 bits the table keeps.
      val = $urandom;
      val[OFF_W-1:0] = OFF_W'(start);
      send_request(OP_WR_OFF, IDX_W'(bucket), val, $urandom);
      val = $urandom;
      val[OFF_W-1:0] = OFF_W'(start + len);
      send_request(OP_WR_OFF, IDX_W'(bucket + 1), val, $urandom);
      foreach (locs[i]) send_request(OP_WR_LOC, IDX_W'(start + i), locs[i], $urandom);
      built_buckets = {built_buckets, bucket};
      buckets_loaded++;
      repeat ($urandom_range(2, 6)) query_bucket(bucket);
   endtask

   // Arbitrary request of any opcode, kept off unwritten entries.
   task automatic send_noise();
      logic [OP_W-1:0]  op;
      logic [IDX_W-1:0] idx;
      op  = $urandom_range(0, 7);
      idx = $urandom;
      if (!board.query_is_defined(op, idx)) idx[IDX_W-1] = 1'b1;
      send_request(op, idx, $urandom, $urandom);
   endtask

   // Response side: random stall before each transfer, then check it.
   initial begin
      int stall;
      index_answer_type got;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         stall = rsp_idle_on ? $urandom_range(0, MAX_GAP) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         got.found         = rsp_tuser[0];
         got.position      = rsp_tdata[IDX_W-1:0];
         got.count         = rsp_tdata[IDX_W +: CNT_W];
         got.location_word = rsp_tdata[IDX_W+CNT_W +: WORD_W];
         board.check_response(got);
      end
   end

   // Request side: reset, directed cases, random traffic, drain.
   initial begin
      int pick;
      int phase_mark;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Last bucket runs past the store and is clamped; its words hit both extremes.
      send_request(OP_WR_OFF, IDX_W'(NUM_BUCKETS - 1), 32'hFFFE_FFFA, '0);
      send_request(OP_WR_OFF, IDX_W'(NUM_BUCKETS), '1, '1);
      send_request(OP_WR_LOC, IDX_W'(STORE_DEPTH - 6), '0, '0);
      send_request(OP_WR_LOC, IDX_W'(STORE_DEPTH - 5), 32'd5, '0);
      send_request(OP_WR_LOC, IDX_W'(STORE_DEPTH - 4), 32'd1000, '0);
      send_request(OP_WR_LOC, IDX_W'(STORE_DEPTH - 3), 32'h8000_0000, '0);
      send_request(OP_WR_LOC, IDX_W'(STORE_DEPTH - 2), 32'hFFFF_FFF0, '0);
      send_request(OP_WR_LOC, IDX_W'(STORE_DEPTH - 1), '1, '0);
      send_request(OP_RANGE, IDX_W'(NUM_BUCKETS - 1), '0, '0);
      // Window bottom saturates at zero, then window top saturates.
      send_request(OP_NEAR, IDX_W'(NUM_BUCKETS - 1), 32'd3, 32'd10);
      send_request(OP_NEAR, IDX_W'(NUM_BUCKETS - 1), 32'hFFFF_FFFE, '1);
      send_request(OP_EXACT, IDX_W'(NUM_BUCKETS - 1), 32'd1000, '0);
      send_request(OP_EXACT, IDX_W'(NUM_BUCKETS - 1), 32'd7, '0);
      send_request(OP_RD_LOC, IDX_W'(STORE_DEPTH - 1), '0, '0);
      // Indexes beyond either table.
      send_request(OP_RD_LOC, '1, '0, '0);
      send_request(OP_WR_LOC, '1, 32'h1234_5678, '0);
      send_request(OP_WR_OFF, '1, 32'h0000_0042, '0);
      // Empty bucket, then an inverted one.
      send_request(OP_WR_OFF, IDX_W'(100), 32'd10, '0);
      send_request(OP_WR_OFF, IDX_W'(101), 32'd10, '0);
      send_request(OP_NEAR, IDX_W'(100), 32'd10, '1);
      send_request(OP_WR_OFF, IDX_W'(200), 32'd20, '0);
      send_request(OP_WR_OFF, IDX_W'(201), 32'd5, '0);
      send_request(OP_RANGE, IDX_W'(200), '0, '0);
      // Bucket number out of range and the two unused opcodes.
      send_request(OP_RANGE, '1, '0, '0);
      send_request(OP_RSVD6, IDX_W'($urandom), $urandom, $urandom);
      send_request(OP_RSVD7, '1, '1, '1);

      // Random traffic, mostly loaded buckets followed by queries on them.
      phase_mark = items_sent;
      while (items_sent < ITEM_TARGET) begin
         if (items_sent - phase_mark >= 150) begin
            phase_mark  = items_sent;
            req_idle_on = ($urandom_range(0, 3) != 0);
            rsp_idle_on = ($urandom_range(0, 3) != 0);
         end
         pick = $urandom_range(0, 99);
         if (pick < 25 || built_buckets.size() == 0)
            build_bucket();
         else if (pick < 88)
            query_bucket(built_buckets[$urandom_range(0, built_buckets.size() - 1)]);
         else
            send_noise();
      end
      req_tvalid <= 1'b0;

      // Let every outstanding response arrive, then idle for the drain period.
      while (board.pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests sent, %0d responses checked, %0d with found set",
               items_sent, board.checked, board.hits);
      $display("%0d buckets loaded, %0d mismatches, %0d cycles",
               buckets_loaded, board.mismatches, cycle_count);
      if (board.mismatches == 0 && board.pending_answers.size() == 0)
         $display("tb_kmer_location_index_search: clean");
      else
         $display("tb_kmer_location_index_search: errors");
      $finish;
   end

endmodule
